// ===== design/bilinear_image_scaler_assert.svh =====
// ----------------------------------------------------------------------------
// Bilinear image scaler assertion macros
// Shared property forms for the checker of the bilinear scaler.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_SCALER_ASSERT_SVH
`define BILINEAR_IMAGE_SCALER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BIS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bilinear scaler: implication check failed");

// Implication with a fixed delay, disabled while reset is asserted.
`define BIS_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("bilinear scaler: delayed check failed");

`endif

// ===== design/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilinear image scaler package
// Field widths, codes and the item type shared by the scaler files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

  localparam int POS_W     = 12;
  localparam int CH_W      = 2;
  localparam int SMP_W     = 8;
  localparam int SRC_CFG_W = 9;
  localparam int DST_CFG_W = 13;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2,
    CFG_DST_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [CH_W-1:0]    ch;
    logic [SMP_W-1:0]   smp;
  } item_t;

endpackage

`default_nettype wire

// ===== design/bis_ram.sv =====
// ----------------------------------------------------------------------------
// Bilinear image scaler RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_ram #(
  parameter int  WIDTH  = 8,
  parameter int  DEPTH  = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/bis_axis.sv =====
// ----------------------------------------------------------------------------
// Bilinear image scaler axis mapper
// Maps a destination coordinate to two clamped source indices and a fraction
// through a pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_axis #(
  parameter int IDX_W     = 8,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic [bis_pkg::POS_W-1:0]      pos_i,
  input  wire logic [IDX_W:0]                 srcn_i,
  input  wire logic [bis_pkg::DST_CFG_W-1:0]  dstn_i,
  output logic      [IDX_W-1:0]               idx0_o,
  output logic      [IDX_W-1:0]               idx1_o,
  output logic      [FRAC_BITS-1:0]           frac_o
);

  import bis_pkg::*;

  localparam int QW = IDX_W + FRAC_BITS;
  localparam int DW = DST_CFG_W;
  localparam int PW = POS_W + IDX_W + 1;
  localparam int LW = IDX_W + DW;
  localparam int CW = (PW > LW) ? PW : LW;

  // Products: scaled position and the saturation limit (last * dstn).
  logic [PW-1:0]    prod_q;
  logic [LW-1:0]    lim_q;
  logic [IDX_W-1:0] last_q;
  logic [DW-1:0]    den_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(pos_i) * PW'(srcn_i);
    lim_q  <= LW'(srcn_i - 1'b1) * LW'(dstn_i);
    last_q <= IDX_W'(srcn_i - 1'b1);
    den_q  <= dstn_i;
  end

  // Divider stage inputs and registers.
  logic [DW-1:0]    rem_in  [QW];
  logic [QW-1:0]    quo_in  [QW];
  logic [QW-1:0]    lo_in   [QW];
  logic [DW-1:0]    den_in  [QW];
  logic [IDX_W-1:0] last_in [QW];
  logic             sat_in  [QW];

  logic [DW-1:0]    rem_q  [QW];
  logic [QW-1:0]    quo_q  [QW];
  logic [QW-1:0]    lo_q   [QW];
  logic [DW-1:0]    den_sq [QW];
  logic [IDX_W-1:0] last_sq[QW];
  logic             sat_q  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [DW:0] trial;

    if (i == 0) begin : g_first
      // The quotient fits QW bits whenever the position is not saturated, so
      // the bits above QW of the dividend already form a remainder below dstn.
      assign rem_in[i]  = DW'(prod_q >> IDX_W);
      assign quo_in[i]  = '0;
      assign lo_in[i]   = {prod_q[IDX_W-1:0], {FRAC_BITS{1'b0}}};
      assign den_in[i]  = den_q;
      assign last_in[i] = last_q;
      assign sat_in[i]  = CW'(prod_q) >= CW'(lim_q);
    end else begin : g_next
      assign rem_in[i]  = rem_q[i-1];
      assign quo_in[i]  = quo_q[i-1];
      assign lo_in[i]   = lo_q[i-1];
      assign den_in[i]  = den_sq[i-1];
      assign last_in[i] = last_sq[i-1];
      assign sat_in[i]  = sat_q[i-1];
    end

    assign trial = {rem_in[i], lo_in[i][QW-1-i]};

    always_ff @(posedge clk_i) begin
      if (trial >= {1'b0, den_in[i]}) begin
        rem_q[i] <= DW'(trial - {1'b0, den_in[i]});
        quo_q[i] <= quo_in[i] | (QW'(1) << (QW-1-i));
      end else begin
        rem_q[i] <= DW'(trial);
        quo_q[i] <= quo_in[i];
      end
      lo_q[i]    <= lo_in[i];
      den_sq[i]  <= den_in[i];
      last_sq[i] <= last_in[i];
      sat_q[i]   <= sat_in[i];
    end
  end

  logic [IDX_W-1:0] ip;
  assign ip = quo_q[QW-1][QW-1:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    frac_o <= quo_q[QW-1][FRAC_BITS-1:0];
    if (sat_q[QW-1]) begin
      idx0_o <= last_sq[QW-1];
      idx1_o <= last_sq[QW-1];
    end else begin
      idx0_o <= ip;
      idx1_o <= IDX_W'(ip + 1'b1);
    end
  end

endmodule

`default_nettype wire

// ===== design/bilinear_image_scaler.sv =====
// ----------------------------------------------------------------------------
// Bilinear image scaler
// Frame store with a fully pipelined bilinear resampler behind it.
// ----------------------------------------------------------------------------
// Usage:
// An item is presented on mode_i, pos_x_i, pos_y_i, channel_i and sample_in_i
// and is taken at a rising edge where start_i is high and busy_o is low. A
// write item (mode 0) stores one source sample and gives no result; a read
// item (mode 1) asks for one destination sample. busy_o is high only during
// and just after reset, so an item can be taken in every cycle.
// Each result appears on out_x_o, out_y_o, out_channel_o and sample_out_o for
// one cycle with done_o high. The receiver cannot stall the block, and none
// is needed: results leave in the same order, one per cycle at most.
// Results pass the input register, the delay line beside both axis mappers, the
// address stage, the bank read, the horizontal blend and the output register;
// the mapper depth is set by the restoring divider that forms the source position,
// one quotient bit per stage. Throughput is one item per cycle. The user must
// write the configuration registers over cfg_valid_i / cfg_ready_o only while no
// item is in flight; the block does not enforce it. Reset clears the valid flags,
// raises busy_o, loads default sizes; the frame store is undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bilinear_image_scaler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int CHANNELS   = 3,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Item channel
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic                           mode_i,
  input  wire logic [bis_pkg::POS_W-1:0]      pos_x_i,
  input  wire logic [bis_pkg::POS_W-1:0]      pos_y_i,
  input  wire logic [bis_pkg::CH_W-1:0]       channel_i,
  input  wire logic [bis_pkg::SMP_W-1:0]      sample_in_i,
  // Result channel
  output logic                                done_o,
  output logic      [bis_pkg::POS_W-1:0]      out_x_o,
  output logic      [bis_pkg::POS_W-1:0]      out_y_o,
  output logic      [bis_pkg::CH_W-1:0]       out_channel_o,
  output logic      [bis_pkg::SMP_W-1:0]      sample_out_o,
  // Configuration channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bis_pkg::DST_CFG_W-1:0]  cfg_data_i
);

  import bis_pkg::*;

  // Index width shared by both axes so that the two mappers line up.
  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int AXW     = (XW > YW) ? XW : YW;
  localparam int AXL     = AXW + FRAC_BITS + 2;
  localparam int HALF_W  = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H  = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_D  = HALF_W * HALF_H * CHANNELS;
  localparam int BANK_AW = (BANK_D > 1) ? $clog2(BANK_D) : 1;
  localparam int HW      = SMP_W + FRAC_BITS;
  localparam int VW      = SMP_W + 2 * FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] ONE_FRAC = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  function automatic logic [AXW:0] eff_src(input logic [SRC_CFG_W-1:0] v, input int maxv);
    logic [AXW:0] r;
    if (v == '0) begin
      r = (AXW + 1)'(1);
    end else if (32'(v) > maxv) begin
      r = (AXW + 1)'(maxv);
    end else begin
      r = (AXW + 1)'(v);
    end
    return r;
  endfunction

  function automatic logic [DST_CFG_W-1:0] eff_dst(input logic [DST_CFG_W-1:0] v);
    return (v == '0) ? DST_CFG_W'(1) : v;
  endfunction

  // Samples live in four banks chosen by column and row parity, so that the
  // four neighbours of any position are always in four distinct banks (or
  // coincide when clamped at an edge).
  function automatic logic [BANK_AW-1:0] bank_addr(input int col, input int row, input int c);
    return BANK_AW'((row * HALF_W + col) * CHANNELS + c);
  endfunction

  // --------------------------------------------------------------------------
  // Reset status and configuration
  // --------------------------------------------------------------------------
  logic busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o      = busy_q;
  assign cfg_ready_o = ~busy_q;

  // The registers hold effective sizes: zero values, and out-of-range source
  // sizes, are folded in when written.
  logic [AXW:0]           src_w_q, src_h_q;
  logic [DST_CFG_W-1:0]   dst_w_q, dst_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= eff_src(SRC_CFG_W'(256), MAX_WIDTH);
      src_h_q <= eff_src(SRC_CFG_W'(256), MAX_HEIGHT);
      dst_w_q <= DST_CFG_W'(256);
      dst_h_q <= DST_CFG_W'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SRC_WIDTH:  src_w_q <= eff_src(cfg_data_i[SRC_CFG_W-1:0], MAX_WIDTH);
        CFG_SRC_HEIGHT: src_h_q <= eff_src(cfg_data_i[SRC_CFG_W-1:0], MAX_HEIGHT);
        CFG_DST_WIDTH:  dst_w_q <= eff_dst(cfg_data_i);
        CFG_DST_HEIGHT: dst_h_q <= eff_dst(cfg_data_i);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register and item delay line alongside the axis mappers
  // --------------------------------------------------------------------------
  item_t item_q [AXL+1];
  logic  vld_q  [AXL+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= AXL; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= start_i && !busy_q;
      for (int k = 1; k <= AXL; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q[0] <= '{mode: mode_e'(mode_i), x: pos_x_i, y: pos_y_i, ch: channel_i,
                   smp: sample_in_i};
    for (int k = 1; k <= AXL; k++) begin
      item_q[k] <= item_q[k-1];
    end
  end

  logic [AXW-1:0]       x0, x1, y0, y1;
  logic [FRAC_BITS-1:0] fx, fy;

  bis_axis #(
    .IDX_W     (AXW),
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_x (
    .clk_i  (clk_i),
    .pos_i  (item_q[0].x),
    .srcn_i (src_w_q),
    .dstn_i (dst_w_q),
    .idx0_o (x0),
    .idx1_o (x1),
    .frac_o (fx)
  );

  bis_axis #(
    .IDX_W     (AXW),
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_y (
    .clk_i  (clk_i),
    .pos_i  (item_q[0].y),
    .srcn_i (src_h_q),
    .dstn_i (dst_h_q),
    .idx0_o (y0),
    .idx1_o (y1),
    .frac_o (fy)
  );

  // --------------------------------------------------------------------------
  // Address stage: bank addresses for a read, or the one bank for a write.
  // Writes travel the same depth as reads so that stores and lookups keep
  // item order.
  // --------------------------------------------------------------------------
  item_t                a_item_q;
  logic                 a_vld_q;
  logic [BANK_AW-1:0]   a_addr_q [4];
  logic [3:0]           a_we_q;
  logic [3:0]           a_par_q;     // {y1, y0, x1, x0} parity bits
  logic [FRAC_BITS-1:0] a_fx_q, a_fy_q;

  item_t                cur;
  int                   col_even, col_odd, row_even, row_odd, rd_ch;
  logic                 wr_ok;
  logic [1:0]           wr_bank;
  logic [BANK_AW-1:0]   addr_d [4];
  logic [3:0]           we_d;

  always_comb begin
    cur      = item_q[AXL];
    col_even = x0[0] ? 32'(x1) : 32'(x0);
    col_odd  = x0[0] ? 32'(x0) : 32'(x1);
    row_even = y0[0] ? 32'(y1) : 32'(y0);
    row_odd  = y0[0] ? 32'(y0) : 32'(y1);
    rd_ch    = (32'(cur.ch) < CHANNELS) ? 32'(cur.ch) : 0;
    wr_ok    = (32'(cur.x) < MAX_WIDTH) && (32'(cur.y) < MAX_HEIGHT) &&
               (32'(cur.ch) < CHANNELS);
    wr_bank  = {cur.y[0], cur.x[0]};
    for (int b = 0; b < 4; b++) begin
      if (cur.mode == MODE_WRITE) begin
        addr_d[b] = bank_addr(32'(cur.x) >> 1, 32'(cur.y) >> 1, wr_ok ? 32'(cur.ch) : 0);
        we_d[b]   = vld_q[AXL] && wr_ok && (wr_bank == 2'(b));
      end else begin
        addr_d[b] = bank_addr(((b & 1) != 0) ? (col_odd >> 1) : (col_even >> 1),
                              ((b & 2) != 0) ? (row_odd >> 1) : (row_even >> 1), rd_ch);
        we_d[b]   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      a_we_q  <= '0;
    end else begin
      a_vld_q <= vld_q[AXL];
      a_we_q  <= we_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_item_q <= cur;
    a_addr_q <= addr_d;
    a_par_q  <= {y1[0], y0[0], x1[0], x0[0]};
    a_fx_q   <= fx;
    a_fy_q   <= fy;
  end

  // --------------------------------------------------------------------------
  // Frame store banks, index {row parity, column parity}
  // --------------------------------------------------------------------------
  logic [SMP_W-1:0] bank_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bis_ram #(
      .WIDTH (SMP_W),
      .DEPTH (BANK_D)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (a_we_q[b]),
      .waddr_i (a_addr_q[b]),
      .wdata_i (a_item_q.smp),
      .raddr_i (a_addr_q[b]),
      .rdata_o (bank_q[b])
    );
  end

  item_t                r_item_q;
  logic                 r_vld_q;
  logic [3:0]           r_par_q;
  logic [FRAC_BITS-1:0] r_fx_q, r_fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else begin
      r_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_item_q <= a_item_q;
    r_par_q  <= a_par_q;
    r_fx_q   <= a_fx_q;
    r_fy_q   <= a_fy_q;
  end

  // --------------------------------------------------------------------------
  // Horizontal blend of the top and bottom neighbour pairs
  // --------------------------------------------------------------------------
  logic [SMP_W-1:0] v00, v10, v01, v11;
  logic [HW-1:0]    top_d, bot_d;

  always_comb begin
    v00   = bank_q[{r_par_q[2], r_par_q[0]}];
    v10   = bank_q[{r_par_q[2], r_par_q[1]}];
    v01   = bank_q[{r_par_q[3], r_par_q[0]}];
    v11   = bank_q[{r_par_q[3], r_par_q[1]}];
    top_d = HW'(HW'(v00) * HW'(ONE_FRAC - (FRAC_BITS + 1)'(r_fx_q)) + HW'(v10) * HW'(r_fx_q));
    bot_d = HW'(HW'(v01) * HW'(ONE_FRAC - (FRAC_BITS + 1)'(r_fx_q)) + HW'(v11) * HW'(r_fx_q));
  end

  item_t                h_item_q;
  logic                 h_vld_q;
  logic [HW-1:0]        h_top_q, h_bot_q;
  logic [FRAC_BITS-1:0] h_fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else begin
      h_vld_q <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h_item_q <= r_item_q;
    h_top_q  <= top_d;
    h_bot_q  <= bot_d;
    h_fy_q   <= r_fy_q;
  end

  // --------------------------------------------------------------------------
  // Vertical blend and output register. The weighted sum never exceeds
  // 255 << 2F, so dropping the fraction bits gives the truncated sample.
  // An absent channel gives zero.
  // --------------------------------------------------------------------------
  logic [VW-1:0] vsum;

  assign vsum = VW'(h_top_q) * VW'(ONE_FRAC - (FRAC_BITS + 1)'(h_fy_q)) +
                VW'(h_bot_q) * VW'(h_fy_q);

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= h_vld_q && (h_item_q.mode == MODE_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_o       <= h_item_q.x;
    out_y_o       <= h_item_q.y;
    out_channel_o <= h_item_q.ch;
    sample_out_o  <= (32'(h_item_q.ch) < CHANNELS) ?
                     vsum[2*FRAC_BITS +: SMP_W] : '0;
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== design/bis_checker.sv =====
// ----------------------------------------------------------------------------
// Bilinear image scaler checker
// Port-level checks on request/result pairing and result contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bilinear_image_scaler_assert.svh"

module bis_checker #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int CHANNELS   = 3,
  parameter int FRAC_BITS  = 8
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           start_i,
  input wire logic                           busy_o,
  input wire logic                           mode_i,
  input wire logic [bis_pkg::POS_W-1:0]      pos_x_i,
  input wire logic [bis_pkg::POS_W-1:0]      pos_y_i,
  input wire logic [bis_pkg::CH_W-1:0]       channel_i,
  input wire logic                           done_o,
  input wire logic [bis_pkg::POS_W-1:0]      out_x_o,
  input wire logic [bis_pkg::POS_W-1:0]      out_y_o,
  input wire logic [bis_pkg::CH_W-1:0]       out_channel_o,
  input wire logic [bis_pkg::SMP_W-1:0]      sample_out_o
);

  import bis_pkg::*;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int AXW = (XW > YW) ? XW : YW;
  localparam int LAT = AXW + FRAC_BITS + 7;

  logic req_acc;
  assign req_acc = start_i && !busy_o && (mode_i == MODE_READ);

  // Every accepted read item yields a result, and a result comes only from one.
  `BIS_ASSERT_DELAY(a_req_gives_done, clk_i, rst_ni, req_acc, LAT, done_o)
  `BIS_ASSERT_IMPLY(a_done_has_req, clk_i, rst_ni, done_o, $past(req_acc, LAT))
  // The result carries the coordinates of its own item.
  `BIS_ASSERT_IMPLY(a_done_coords, clk_i, rst_ni, done_o, (out_x_o == $past(pos_x_i, LAT)) && (out_y_o == $past(pos_y_i, LAT)) && (out_channel_o == $past(channel_i, LAT)))
  // An absent channel reads as zero.
  `BIS_ASSERT_IMPLY(a_absent_zero, clk_i, rst_ni, done_o && (32'(out_channel_o) >= CHANNELS), sample_out_o == '0)

endmodule

bind bilinear_image_scaler bis_checker #(
  .MAX_WIDTH  (MAX_WIDTH),
  .MAX_HEIGHT (MAX_HEIGHT),
  .CHANNELS   (CHANNELS),
  .FRAC_BITS  (FRAC_BITS)
) u_bis_checker (.*);

`default_nettype wire
